// ===== sv/radix_base_converter_top_macros.svh =====
// Assertion macros used by the radix base converter checker.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef RADIX_BASE_CONVERTER_TOP_MACROS_SVH
`define RADIX_BASE_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define RBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbc checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is held
`define RBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbc checker: next-cycle property failed");

`endif

// ===== sv/rbc_pkg.sv =====
// Shared types and constants for the radix base converter.
// No dependencies; imported by every module of the block but rbc_ram.
package rbc_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned BASE_W    = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_BASE = 4'd0,
    REG_TARGET_BASE = 4'd1
  } rbc_reg_t;

  // Result error codes
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_SRC_BASE    = 3'd1,
    ERR_TGT_BASE    = 3'd2,
    ERR_LEAD_ZERO   = 3'd3,
    ERR_DIGIT_RANGE = 3'd4
  } rbc_err_t;

  localparam logic [BASE_W-1:0] BASE_MIN        = 32'd2;
  localparam logic [BASE_W-1:0] SRC_BASE_RESET  = 32'd10;
  localparam logic [BASE_W-1:0] TGT_BASE_RESET  = 32'd2;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rbc_div_stat_t;

endpackage

// ===== sv/rbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the remainder stack.
module rbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== sv/rbc_div.sv =====
// Bit-serial restoring divider: ACC_WIDTH-bit dividend by a 32-bit divisor.
// Depends on rbc_pkg for the status struct; one quotient bit per cycle.
module rbc_div #(
  parameter int unsigned ACC_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ACC_WIDTH-1:0]         dividend,
  input  logic [rbc_pkg::BASE_W-1:0]   divisor,
  output rbc_pkg::rbc_div_stat_t       stat,
  output logic [ACC_WIDTH-1:0]         quotient,
  output logic [rbc_pkg::BASE_W-1:0]   remainder
);
  import rbc_pkg::*;

  localparam int unsigned CW = $clog2(ACC_WIDTH + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [ACC_WIDTH-1:0] q_r, q_nxt;
  logic [BASE_W-1:0] rem_r, rem_nxt;
  logic [BASE_W:0]   trial;
  logic [BASE_W:0]   diff;
  logic              ge;

  // shift-subtract step: dividend bits leave at the top, quotient bits enter below
  always_comb begin
    trial    = {rem_r, q_r[ACC_WIDTH-1]};
    ge       = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(ACC_WIDTH);
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[ACC_WIDTH-2:0], ge};
      rem_nxt = ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ===== sv/radix_base_converter_top.sv =====
// Radix base converter: top level with sequencer, shared multiplier and stack.
// Depends on rbc_pkg, rbc_div and rbc_ram.
//
// Usage: digits of one number arrive on the in_ channel, most significant
// first, in radix source_base; in_last ends the number, in_empty_number ends
// it with no digits. Results leave on the out_ channel, most significant
// target digit first, with out_last on the final one; an error gives a single
// result carrying out_error_code. Bases are written on the cfg_ channel
// (index 0 source, 1 target), always ready; the user must write them only while the
// block is idle, which the block itself does not enforce. Each digit is accepted,
// then goes as two 32x32 partial products through the one multiplier. The final
// item adds a check state, then one bit-serial division per target digit, then a
// stack read, output load and transfer per emitted digit. After the final item is
// accepted, in_stall stays high until the last result of the number is taken;
// after other digits it drops once the multiply is done. A stalled result holds
// its value and the sequencer waits. Reset sets the bases to 10 and 2, clears the
// number state and drops out_valid; the stack needs no clearing.
module radix_base_converter_top #(
  parameter int unsigned OUT_DEPTH = 64,
  parameter int unsigned ACC_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rbc_pkg::BASE_W-1:0]    in_digit,
  input  logic                          in_last,
  input  logic                          in_empty_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rbc_pkg::BASE_W-1:0]    out_digit,
  output logic                          out_last,
  output logic [2:0]                    out_error_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbc_pkg::BASE_W-1:0]    cfg_data
);
  import rbc_pkg::*;

  localparam int unsigned AW    = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_CHECK, S_DIV_GO, S_DIV_WAIT,
    S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [BASE_W-1:0]    src_base_r, src_base_nxt;
  logic [BASE_W-1:0]    tgt_base_r, tgt_base_nxt;
  logic [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic [63:0]          tmp_r, tmp_nxt;
  logic [1:0]           seen_r, seen_nxt;
  logic                 fdz_r, fdz_nxt;
  logic                 pend_r, pend_nxt;
  logic                 empty_r, empty_nxt;
  logic                 last_r, last_nxt;
  logic [BASE_W-1:0]    digit_r, digit_nxt;
  logic [ACC_WIDTH-1:0] v_r, v_nxt;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [AW-1:0]        rp_r, rp_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     left_r, left_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BASE_W-1:0]    out_digit_r, out_digit_nxt;
  logic                 out_last_r, out_last_nxt;
  rbc_err_t             out_err_r, out_err_nxt;

  logic [63:0]          acc_ext;
  logic [BASE_W-1:0]    mul_a;
  logic [63:0]          prod;
  rbc_err_t             code;
  logic [CNT_W-1:0]     cnt_inc;
  logic [AW-1:0]        wp_inc;

  logic                 div_start;
  rbc_div_stat_t        div_stat;
  logic [ACC_WIDTH-1:0] div_q;
  logic [BASE_W-1:0]    div_rem;

  logic                 ram_we;
  logic                 ram_re;
  logic [BASE_W-1:0]    ram_rdata;

  // shared 32x32 multiplier: low half of the accumulator, then high half
  assign acc_ext = 64'(acc_r);
  assign mul_a   = (state_r == S_MUL_HI) ? acc_ext[63:32] : acc_ext[31:0];
  assign prod    = 64'(mul_a) * 64'(src_base_r);

  // error priority at the end of a number
  always_comb begin
    if (src_base_r < BASE_MIN) begin
      code = ERR_SRC_BASE;
    end else if (tgt_base_r < BASE_MIN) begin
      code = ERR_TGT_BASE;
    end else if (!empty_r && seen_r == 2'd2 && fdz_r) begin
      code = ERR_LEAD_ZERO;
    end else if (!empty_r && pend_r) begin
      code = ERR_DIGIT_RANGE;
    end else begin
      code = ERR_NONE;
    end
  end

  assign cnt_inc = (cnt_r == CNT_W'(OUT_DEPTH)) ? cnt_r : cnt_r + CNT_W'(1);
  assign wp_inc  = (wp_r == AW'(OUT_DEPTH - 1)) ? '0 : wp_r + AW'(1);

  // sequencer next-state and datapath
  always_comb begin
    state_nxt     = state_r;
    src_base_nxt  = src_base_r;
    tgt_base_nxt  = tgt_base_r;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    seen_nxt      = seen_r;
    fdz_nxt       = fdz_r;
    pend_nxt      = pend_r;
    empty_nxt     = empty_r;
    last_nxt      = last_r;
    digit_nxt     = digit_r;
    v_nxt         = v_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    // register writes
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOURCE_BASE: src_base_nxt = cfg_data;
        REG_TARGET_BASE: tgt_base_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_empty_number) begin
            empty_nxt = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            if (seen_r == 2'd0 && in_digit == '0) begin
              fdz_nxt = 1'b1;
            end
            if (seen_r != 2'd2) begin
              seen_nxt = seen_r + 2'd1;
            end
            if (in_digit >= src_base_r) begin
              pend_nxt = 1'b1;
            end
            empty_nxt = 1'b0;
            digit_nxt = in_digit;
            last_nxt  = in_last;
            state_nxt = S_MUL_LO;
          end
        end
      end
      S_MUL_LO: begin
        tmp_nxt   = prod + 64'(digit_r);
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        acc_nxt   = ACC_WIDTH'(tmp_r + {prod[31:0], 32'd0});
        state_nxt = last_r ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        acc_nxt  = '0;
        seen_nxt = 2'd0;
        fdz_nxt  = 1'b0;
        pend_nxt = 1'b0;
        if (code != ERR_NONE || empty_r || acc_r == '0) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = code;
          state_nxt     = S_EMIT_WAIT;
        end else begin
          v_nxt     = acc_r;
          wp_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          ram_we  = 1'b1;
          wp_nxt  = wp_inc;
          cnt_nxt = cnt_inc;
          if (div_q == '0) begin
            rp_nxt    = wp_r;
            left_nxt  = cnt_inc;
            state_nxt = S_EMIT_RD;
          end else begin
            v_nxt     = div_q;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_EMIT_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_digit_nxt = ram_rdata;
        out_last_nxt  = (left_r == CNT_W'(1));
        out_err_nxt   = ERR_NONE;
        state_nxt     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            rp_nxt    = (rp_r == '0) ? AW'(OUT_DEPTH - 1) : rp_r - AW'(1);
            left_nxt  = left_r - CNT_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      src_base_r  <= SRC_BASE_RESET;
      tgt_base_r  <= TGT_BASE_RESET;
      acc_r       <= '0;
      seen_r      <= 2'd0;
      fdz_r       <= 1'b0;
      pend_r      <= 1'b0;
      empty_r     <= 1'b0;
      last_r      <= 1'b0;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_err_r   <= ERR_NONE;
    end else begin
      state_r     <= state_nxt;
      src_base_r  <= src_base_nxt;
      tgt_base_r  <= tgt_base_nxt;
      acc_r       <= acc_nxt;
      seen_r      <= seen_nxt;
      fdz_r       <= fdz_nxt;
      pend_r      <= pend_nxt;
      empty_r     <= empty_nxt;
      last_r      <= last_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      out_err_r   <= out_err_nxt;
    end
    tmp_r       <= tmp_nxt;
    digit_r     <= digit_nxt;
    v_r         <= v_nxt;
    out_digit_r <= out_digit_nxt;
  end

  // iterative divider, shared by every target digit
  rbc_div #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (v_r),
    .divisor   (tgt_base_r),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // remainder stack, a ring that keeps the newest OUT_DEPTH remainders
  rbc_ram #(
    .WIDTH (BASE_W),
    .DEPTH (OUT_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_digit      = out_digit_r;
  assign out_last       = out_last_r;
  assign out_error_code = out_err_r;

endmodule

// ===== sv/rbc_checker.sv =====
// Port-level checker for the radix base converter, bound to the top level.
// Depends on rbc_pkg and radix_base_converter_top_macros.svh.
`include "radix_base_converter_top_macros.svh"

module rbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rbc_pkg::BASE_W-1:0] out_digit,
  input logic                       out_last,
  input logic [2:0]                 out_error_code
);
  import rbc_pkg::*;

  // no new input while a result transaction is pending
  `RBC_ASSERT_NOW(a_busy_while_out, out_valid, in_stall)

  // an error result is a lone zero digit that closes the number
  `RBC_ASSERT_NOW(a_err_single, out_valid && out_error_code != ERR_NONE,
                  out_last && out_digit == '0)

  // a transferred result is never followed by a result in the next cycle
  `RBC_ASSERT_NEXT(a_gap_after_out, out_valid && !out_stall, !out_valid)

  // stalled result holds
  `RBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_digit) && $stable(out_last))

endmodule

bind radix_base_converter_top rbc_checker u_rbc_checker (.*);

// ===== tb/sv/radix_base_converter_top_tb.sv =====
// Self-checking testbench for radix_base_converter_top: directed and random numbers
// under several base settings, with a scoreboard that recomputes every target digit.
// Depends on rbc_pkg and the radix_base_converter_top RTL only.
module radix_base_converter_top_tb;
  import rbc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam longint     LIMIT_CYCLES  = 8_000_000;

  // One expected result transaction
  typedef struct {
    logic [BASE_W-1:0] digit;
    logic              last;
    rbc_err_t          code;
  } target_digit_t;

  // Scoreboard: tracks the number being assembled and queues its target digits
  class rbc_conversion_scoreboard;
    logic [BASE_W-1:0] src_base = SRC_BASE_RESET;
    logic [BASE_W-1:0] tgt_base = TGT_BASE_RESET;
    logic [63:0]       acc = '0;
    int unsigned       digits_seen = 0;
    bit                first_zero = 0;
    bit                digit_bad = 0;
    target_digit_t     pending_digits[$];
    int unsigned       n_checked = 0;
    int unsigned       n_errors = 0;
    int unsigned       n_numbers = 0;
    int unsigned       n_cfg = 0;

    function void set_register(rbc_reg_t idx, logic [BASE_W-1:0] val);
      n_cfg++;
      if (idx == REG_SOURCE_BASE) begin
        src_base = val;
      end else if (idx == REG_TARGET_BASE) begin
        tgt_base = val;
      end
    endfunction

    // Append one expected result transaction at the tail
    function void queue_result(logic [BASE_W-1:0] digit, bit last, rbc_err_t code);
      target_digit_t t;
      t.digit = digit;
      t.last  = last;
      t.code  = code;
      pending_digits.insert(pending_digits.size(), t);
    endfunction

    // Accepted input transaction: update the number, queue results on its end
    function void note_digit(logic [BASE_W-1:0] d, bit last, bit empty_num);
      rbc_err_t          code;
      logic [63:0]       v;
      logic [63:0]       div;
      logic [BASE_W-1:0] rem[$];
      code = ERR_NONE;
      if (!empty_num) begin
        if (digits_seen == 0 && d == '0) first_zero = 1;
        if (digits_seen < 2) digits_seen++;
        if (d >= src_base) digit_bad = 1;
        acc = acc * {32'd0, src_base} + {32'd0, d};
        if (!last) return;
      end
      // error checks in priority order; bases as they stand now
      if (src_base < BASE_MIN) begin
        code = ERR_SRC_BASE;
      end else if (tgt_base < BASE_MIN) begin
        code = ERR_TGT_BASE;
      end else if (!empty_num && digits_seen >= 2 && first_zero) begin
        code = ERR_LEAD_ZERO;
      end else if (!empty_num && digit_bad) begin
        code = ERR_DIGIT_RANGE;
      end
      v = empty_num ? 64'd0 : acc;
      acc = '0;
      digits_seen = 0;
      first_zero = 0;
      digit_bad = 0;
      n_numbers++;
      if (code != ERR_NONE || v == 64'd0) begin
        queue_result('0, 1'b1, code);
        return;
      end
      // repeated division, most significant remainder ends up in front
      div = {32'd0, tgt_base};
      while (v != 64'd0) begin
        rem.push_front(BASE_W'(v % div));
        v = v / div;
      end
      // a full stack keeps the most significant digits
      while (rem.size() > 64) void'(rem.pop_back());
      foreach (rem[i]) begin
        queue_result(rem[i], (i == rem.size() - 1), ERR_NONE);
      end
    endfunction

    // Accepted result transaction: compare against the oldest expectation
    function void check_result(logic [BASE_W-1:0] digit, logic last, logic [2:0] code);
      target_digit_t exp_d;
      if (pending_digits.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: digit=%0h last=%0b code=%0d",
                 $time, digit, last, code);
        return;
      end
      exp_d = pending_digits.pop_front();
      n_checked++;
      if (digit !== exp_d.digit) begin
        n_errors++;
        $display("%0t: out_digit mismatch: expected %0h actual %0h",
                 $time, exp_d.digit, digit);
      end
      if (last !== exp_d.last) begin
        n_errors++;
        $display("%0t: out_last mismatch: expected %0b actual %0b",
                 $time, exp_d.last, last);
      end
      if (code !== exp_d.code) begin
        n_errors++;
        $display("%0t: out_error_code mismatch: expected %0d actual %0d",
                 $time, exp_d.code, code);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [BASE_W-1:0]    in_digit;
  logic                 in_last;
  logic                 in_empty_number;
  logic                 out_valid;
  logic                 out_stall;
  logic [BASE_W-1:0]    out_digit;
  logic                 out_last;
  logic [2:0]           out_error_code;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BASE_W-1:0]    cfg_data;

  rbc_conversion_scoreboard sb = new;
  bit                       calm_phase = 0;
  int unsigned              n_items_sent = 0;

  radix_base_converter_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_digit        (in_digit),
    .in_last         (in_last),
    .in_empty_number (in_empty_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit       (out_digit),
    .out_last        (out_last),
    .out_error_code  (out_error_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #(LIMIT_CYCLES * 4);
    $display("TB_ERROR");
    $finish;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_digit, out_last, out_error_code);
    end
  end

  // Receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    int unsigned stall_run;
    int unsigned r;
    bit          held;
    stall_run = 0;
    held = 0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && sb.n_checked >= 150 && in_valid === 1'b1) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (calm_phase) begin
        out_stall <= 1'b0;
      end else if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
        end else if (r < 95) begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(10, 50);
        end
      end
    end
  end

  // Mostly short gaps, a few long ones, none in a calm phase
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One input transaction, preceded by gap idle cycles
  task automatic send_item(input logic [BASE_W-1:0] d, input bit last, input bit empty_num,
                           input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_digit        <= d;
    in_last         <= last;
    in_empty_number <= empty_num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_digit(d, last, empty_num);
    n_items_sent++;
  endtask

  task automatic cfg_write(input rbc_reg_t idx, input logic [BASE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain: all expected digits out, then let the sequencer go idle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bases(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] tgt);
    cfg_write(REG_SOURCE_BASE, src);
    cfg_write(REG_TARGET_BASE, tgt);
  endtask

  // One random number: mostly well formed, some leading zeros, bad digits, empties
  task automatic send_number(output int unsigned n_sent);
    int unsigned       kind;
    int unsigned       len;
    int unsigned       bad_pos;
    int unsigned       n_drop;
    logic [BASE_W-1:0] top;
    logic [BASE_W-1:0] d;
    n_sent = 0;
    kind = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
    bad_pos = $urandom_range(0, len - 1);
    top = (sb.src_base >= BASE_MIN) ? sb.src_base - 1 : '1;
    if (kind < 7) begin
      // empty number, sometimes after digits that it throws away
      n_drop = $urandom_range(0, 2);
      for (int unsigned i = 0; i < n_drop; i++) begin
        send_item($urandom_range(0, top), 1'b0, 1'b0, rand_gap());
        n_sent++;
      end
      send_item($urandom, $urandom_range(0, 1), 1'b1, rand_gap());
      n_sent++;
      return;
    end
    for (int unsigned i = 0; i < len; i++) begin
      d = $urandom_range(0, top);
      if (i == 0 && len > 1 && d == '0) d = 1;
      if (kind < 13 && i == 0) d = '0;
      if (kind >= 13 && kind < 19 && i == bad_pos && sb.src_base >= BASE_MIN) begin
        d = $urandom_range(sb.src_base, 32'hFFFF_FFFF);
      end
      send_item(d, i == len - 1, 1'b0, rand_gap());
      n_sent++;
    end
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      send_number(k);
      sent += k;
    end
    settle();
  endtask

  // Main sequence
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_digit        = '0;
    in_last         = 1'b0;
    in_empty_number = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_SOURCE_BASE;
    cfg_data        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset bases (decimal in, binary out)
    send_item('0, 1'b1, 1'b1, 1);                 // empty number
    send_item(32'hFFFF_FFFF, 1'b0, 1'b1, 0);      // empty without last still ends it
    send_item('0, 1'b1, 1'b0, 0);                 // lone zero digit
    send_item(32'd9, 1'b1, 1'b0, 2);
    send_item(32'd1, 1'b0, 1'b0, 0);
    send_item(32'd2, 1'b0, 1'b0, 0);
    send_item(32'd3, 1'b1, 1'b0, 0);
    send_item('0, 1'b0, 1'b0, 0);                 // leading zero
    send_item(32'd5, 1'b1, 1'b0, 0);
    send_item(32'd10, 1'b1, 1'b0, 0);             // digit equal to base
    send_item(32'd7, 1'b0, 1'b0, 1);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b0, 0);
    send_item('0, 1'b0, 1'b0, 0);                 // leading zero beats range error
    send_item(32'd12, 1'b1, 1'b0, 0);
    send_item(32'd4, 1'b0, 1'b0, 0);              // gathered digits dropped by empty
    send_item(32'd2, 1'b0, 1'b0, 0);
    send_item(32'd6, 1'b1, 1'b1, 0);
    calm_phase = 1;
    run_random(20);
    calm_phase = 0;
    run_random(25);

    // widest source base: full digit range, 64 binary output digits
    set_bases(32'hFFFF_FFFF, BASE_MIN);
    send_item(32'hFFFF_FFFE, 1'b0, 1'b0, 0);
    send_item(32'hFFFF_FFFE, 1'b1, 1'b0, 0);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b0, 1);
    run_random(25);

    // widest target base, large output digits
    set_bases(32'h8000_0000, 32'hFFFF_FFFF);
    run_random(20);
    set_bases(BASE_MIN, 32'hFFFF_FFFF);
    run_random(10);

    // hex to decimal, no idling
    calm_phase = 1;
    set_bases(32'd16, 32'd10);
    run_random(20);
    calm_phase = 0;

    // bad bases, both priorities
    set_bases(32'd1, '0);
    run_random(6);
    set_bases(32'd10, '0);
    run_random(6);
    set_bases('0, 32'd7);
    run_random(5);
    set_bases(32'd10, 32'd1);
    run_random(5);

    // assorted small bases
    for (int i = 0; i < 5; i++) begin
      set_bases($urandom_range(2, 40), $urandom_range(2, 40));
      run_random(7);
    end

    $display("Converted %0d numbers from %0d input digits under %0d register writes;",
             sb.n_numbers, n_items_sent, sb.n_cfg);
    $display("checked %0d result digits, %0d mismatches.", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_digits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rbc_pkg.sv
sv/rbc_ram.sv
sv/rbc_div.sv
sv/radix_base_converter_top.sv
sv/rbc_checker.sv
tb/sv/radix_base_converter_top_tb.sv
